[design/wsw_pkg.sv]
// Shared types, constants and helpers for the WebAssembly section walker.
`default_nettype none
package wsw_pkg;

  localparam int MAX_LEN_BYTES_DEF = 10;
  localparam logic [7:0] SECTION_ID_MIN = 8'd1;
  localparam logic [7:0] SECTION_ID_MAX = 8'd11;

  typedef enum logic [2:0] {
    PH_MAGIC   = 3'd0,
    PH_VERSION = 3'd1,
    PH_ID      = 3'd2,
    PH_LEN     = 3'd3,
    PH_BODY    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    EV_HEADER = 2'd0,
    EV_ACCEPT = 2'd1,
    EV_ERROR  = 2'd2
  } event_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_MAGIC = 3'd1,
    ERR_SHORT = 3'd2,
    ERR_ID    = 3'd3,
    ERR_LEN   = 3'd4
  } error_code_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_module;
  } byte_item_t;

  typedef struct packed {
    event_kind_t event_kind;
    logic [3:0]  section_num;
    logic [31:0] section_length;
    logic [31:0] module_version;
    error_code_t error_code;
  } event_item_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'h00;
      2'd1:    val = 8'h61;
      2'd2:    val = 8'h73;
      2'd3:    val = 8'h6D;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

[design/wsw_in_stage.sv]
// Input register stage for module bytes.
`default_nettype none
module wsw_in_stage
  import wsw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_ready,
  input  wire byte_item_t byte_data,
  input  wire logic       advance,
  output logic            item_valid,
  output byte_item_t      item
);

  assign byte_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (byte_ready) begin
      item_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      item <= byte_data;
    end
  end

endmodule
`default_nettype wire

[design/wsw_core.sv]
// Section walker state and per-byte next-state and event logic.
`default_nettype none
module wsw_core
  import wsw_pkg::*;
#(
  parameter int MAX_LEN_BYTES = MAX_LEN_BYTES_DEF
)(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  input  wire byte_item_t item,
  input  wire logic       res_room,
  output logic            advance,
  output logic            res_load,
  output event_item_t     res
);

  localparam int CW = $clog2(MAX_LEN_BYTES + 1);

  phase_t      phase, phase_next;
  logic [1:0]  header_count, header_count_next;
  logic [31:0] version_word, version_word_next;
  logic [31:0] length_accumulator, length_accumulator_next;
  logic [CW-1:0] length_byte_count, length_byte_count_next;
  logic [3:0]  current_id, current_id_next;
  logic [31:0] body_remaining, body_remaining_next;
  logic        error_latched, error_latched_next;

  logic [7:0]    b;
  logic          eom;
  logic          res_valid;
  logic [31:0]   b7;
  logic [31:0]   len_part;
  logic [31:0]   acc_new;
  logic [31:0]   ver_new;
  logic [CW-1:0] cnt_inc;
  logic          cnt_full;
  logic          id_bad;
  logic          magic_bad;

  assign b   = item.data_byte;
  assign eom = item.end_of_module;

  assign b7 = {25'd0, b[6:0]};
  always_comb begin
    case (length_byte_count)
      CW'(0):  len_part = b7;
      CW'(1):  len_part = b7 << 7;
      CW'(2):  len_part = b7 << 14;
      CW'(3):  len_part = b7 << 21;
      CW'(4):  len_part = b7 << 28;
      default: len_part = 32'd0;
    endcase
  end
  assign acc_new  = length_accumulator | len_part;
  assign cnt_inc  = length_byte_count + 1'b1;
  assign cnt_full = cnt_inc >= CW'(MAX_LEN_BYTES);

  always_comb begin
    ver_new = version_word;
    case (header_count)
      2'd0:    ver_new[7:0]   = b;
      2'd1:    ver_new[15:8]  = b;
      2'd2:    ver_new[23:16] = b;
      2'd3:    ver_new[31:24] = b;
      default: ver_new = version_word;
    endcase
  end

  assign id_bad    = (b < SECTION_ID_MIN) || (b > SECTION_ID_MAX);
  assign magic_bad = b != magic_byte(header_count);

  assign advance  = item_valid && (!res_valid || res_room);
  assign res_load = advance && res_valid;

  // Event for the byte in the input register
  always_comb begin
    res_valid = 1'b0;
    res       = '{EV_HEADER, 4'd0, 32'd0, 32'd0, ERR_NONE};
    if (!error_latched) begin
      case (phase)
        PH_MAGIC: begin
          if (magic_bad) begin
            res_valid      = 1'b1;
            res.event_kind = EV_ERROR;
            res.error_code = ERR_MAGIC;
          end else if (eom) begin
            res_valid      = 1'b1;
            res.event_kind = EV_ERROR;
            res.error_code = ERR_SHORT;
          end
        end
        PH_VERSION: begin
          if (eom && header_count == 2'd3) begin
            res_valid          = 1'b1;
            res.event_kind     = EV_ACCEPT;
            res.module_version = ver_new;
          end else if (eom) begin
            res_valid      = 1'b1;
            res.event_kind = EV_ERROR;
            res.error_code = ERR_SHORT;
          end
        end
        PH_ID: begin
          if (id_bad) begin
            res_valid      = 1'b1;
            res.event_kind = EV_ERROR;
            res.error_code = ERR_ID;
          end else if (eom) begin
            res_valid      = 1'b1;
            res.event_kind = EV_ERROR;
            res.error_code = ERR_LEN;
          end
        end
        PH_LEN: begin
          if (b[7]) begin
            if (cnt_full || eom) begin
              res_valid      = 1'b1;
              res.event_kind = EV_ERROR;
              res.error_code = ERR_LEN;
            end
          end else if (eom && acc_new == 32'd0) begin
            res_valid          = 1'b1;
            res.event_kind     = EV_ACCEPT;
            res.module_version = version_word;
          end else if (eom) begin
            res_valid      = 1'b1;
            res.event_kind = EV_ERROR;
            res.error_code = ERR_LEN;
          end else begin
            res_valid          = 1'b1;
            res.event_kind     = EV_HEADER;
            res.section_num    = current_id;
            res.section_length = acc_new;
          end
        end
        PH_BODY: begin
          if (eom && body_remaining == 32'd1) begin
            res_valid          = 1'b1;
            res.event_kind     = EV_ACCEPT;
            res.module_version = version_word;
          end else if (eom) begin
            res_valid      = 1'b1;
            res.event_kind = EV_ERROR;
            res.error_code = ERR_LEN;
          end
        end
        default: begin
          res_valid      = 1'b1;
          res.event_kind = EV_ERROR;
          res.error_code = ERR_MAGIC;
        end
      endcase
    end
  end

  // Walker state update
  always_comb begin
    phase_next              = phase;
    header_count_next       = header_count;
    version_word_next       = version_word;
    length_accumulator_next = length_accumulator;
    length_byte_count_next  = length_byte_count;
    current_id_next         = current_id;
    body_remaining_next     = body_remaining;
    error_latched_next      = error_latched;
    if (advance) begin
      if (eom) begin
        phase_next              = PH_MAGIC;
        header_count_next       = 2'd0;
        version_word_next       = 32'd0;
        length_accumulator_next = 32'd0;
        length_byte_count_next  = '0;
        current_id_next         = 4'd0;
        body_remaining_next     = 32'd0;
        error_latched_next      = 1'b0;
      end else if (!error_latched) begin
        case (phase)
          PH_MAGIC: begin
            if (magic_bad) begin
              error_latched_next = 1'b1;
            end else begin
              header_count_next = header_count + 2'd1;
              if (header_count == 2'd3) begin
                phase_next = PH_VERSION;
              end
            end
          end
          PH_VERSION: begin
            version_word_next = ver_new;
            header_count_next = header_count + 2'd1;
            if (header_count == 2'd3) begin
              phase_next = PH_ID;
            end
          end
          PH_ID: begin
            if (id_bad) begin
              error_latched_next = 1'b1;
            end else begin
              current_id_next         = b[3:0];
              length_accumulator_next = 32'd0;
              length_byte_count_next  = '0;
              phase_next              = PH_LEN;
            end
          end
          PH_LEN: begin
            length_accumulator_next = acc_new;
            length_byte_count_next  = cnt_inc;
            if (b[7]) begin
              if (cnt_full) begin
                error_latched_next = 1'b1;
              end
            end else begin
              body_remaining_next = acc_new;
              phase_next          = (acc_new == 32'd0) ? PH_ID : PH_BODY;
            end
          end
          PH_BODY: begin
            body_remaining_next = body_remaining - 32'd1;
            if (body_remaining == 32'd1) begin
              phase_next = PH_ID;
            end
          end
          default: begin
            error_latched_next = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_MAGIC;
      header_count       <= 2'd0;
      version_word       <= 32'd0;
      length_accumulator <= 32'd0;
      length_byte_count  <= '0;
      current_id         <= 4'd0;
      body_remaining     <= 32'd0;
      error_latched      <= 1'b0;
    end else begin
      phase              <= phase_next;
      header_count       <= header_count_next;
      version_word       <= version_word_next;
      length_accumulator <= length_accumulator_next;
      length_byte_count  <= length_byte_count_next;
      current_id         <= current_id_next;
      body_remaining     <= body_remaining_next;
      error_latched      <= error_latched_next;
    end
  end

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    advance && eom |=> phase == PH_MAGIC && !error_latched && header_count == 2'd0)
    else $error("end of module did not restart the walker");

  a_error_latches: assert property (@(posedge clk) disable iff (rst)
    res_load && res.event_kind == EV_ERROR && !eom |=> error_latched)
    else $error("error event without latched error");

  a_body_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> body_remaining != 32'd0)
    else $error("body phase with nothing left to skip");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ID || phase == PH_LEN || phase == PH_BODY) |-> header_count == 2'd0)
    else $error("header count live after header");

  a_no_event_latched: assert property (@(posedge clk) disable iff (rst)
    error_latched |-> !res_load)
    else $error("event produced while error latched");

endmodule
`default_nettype wire

[design/wsw_out_stage.sv]
// Result register for walker events.
`default_nettype none
module wsw_out_stage
  import wsw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        res_load,
  input  wire event_item_t res,
  output logic             res_room,
  output logic             event_valid,
  input  wire logic        event_ready,
  output event_item_t      event_data
);

  assign res_room = !event_valid || event_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (res_room) begin
      event_valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      event_data <= res;
    end
  end

endmodule
`default_nettype wire

[design/wasm_section_walker.sv]
// Path: a byte is held in the input register, and the event that it causes is
//   registered in the result register, from which it transfers.
// Throughput: one byte per cycle; a byte whose event meets a full, stalled result
//   register waits in the input register, bytes that cause no event never wait.
// Reset: synchronous rst clears the walker to the magic check, empty pipeline.
// An end-of-module byte returns the walker to its reset state after its event.
`default_nettype none
module wasm_section_walker
  import wsw_pkg::*;
#(
  parameter int MAX_LEN_BYTES = MAX_LEN_BYTES_DEF
)(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_ready,
  input  wire byte_item_t  byte_data,
  output logic             event_valid,
  input  wire logic        event_ready,
  output event_item_t      event_data
);

  logic        item_valid;
  byte_item_t  item;
  logic        advance;
  logic        res_load;
  logic        res_room;
  event_item_t res;

  wsw_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  wsw_core #(
    .MAX_LEN_BYTES (MAX_LEN_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .res_room   (res_room),
    .advance    (advance),
    .res_load   (res_load),
    .res        (res)
  );

  wsw_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .res_load    (res_load),
    .res         (res),
    .res_room    (res_room),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .event_data  (event_data)
  );

endmodule
`default_nettype wire
